/* rtl/tdp_pkg.sv */
`default_nettype none

package tdp_pkg;

    localparam int MIN_PRIME        = 2;
    localparam int LAST_SMALL_PRIME = 3;
    localparam int FIRST_DIVISOR    = 5;
    localparam int DIVISOR_STRIDE   = 6;
    localparam int PAIR_OFFSET      = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV3,
        ST_DIV_LO,
        ST_DIV_HI,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

/* rtl/tdp_divider.sv */
`default_nettype none

module tdp_divider #(
    parameter int WIDTH = 31
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int PW     = WIDTH + (WIDTH % 2);
    localparam int STEPS  = PW / 2;
    localparam int CNT_W  = $clog2(STEPS + 1);
    localparam int EXT_W  = PW + 1 - WIDTH;

    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [PW:0]      dv_ext;
    logic [PW:0]      s1, s2, r1, r2;
    logic             ge1, ge2;
    logic [PW-1:0]    q1;

    // two restoring steps per cycle
    always_comb
    begin
        dv_ext = {{EXT_W{1'b0}}, div_reg};
        s1     = {rem_reg, quo_reg[PW-1]};
        ge1    = (s1 >= dv_ext);
        r1     = ge1 ? (s1 - dv_ext) : s1;
        q1     = {quo_reg[PW-2:0], ge1};
        s2     = {r1[PW-1:0], q1[PW-1]};
        ge2    = (s2 >= dv_ext);
        r2     = ge2 ? (s2 - dv_ext) : s2;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = PW'(dividend);
            div_next  = divisor;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = r2[PW-1:0];
            quo_next = {q1[PW-2:0], ge2};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[WIDTH-1:0];
    assign remainder = rem_reg[WIDTH-1:0];

endmodule

`default_nettype wire

/* rtl/trial_division_prime_test.sv */
// trial division primality test, 6k-1 / 6k+1 divisors
//
// input channel: in_valid / in_ready carry one candidate in number per beat.
// output channel: out_valid / out_ready carry one is_prime bit per beat,
// exactly one result beat for every input beat, in order.
// one candidate is worked on at a time; in_ready is high only while idle.
// all remainders and the loop bound come from one shared divider that
// retires two quotient bits per cycle.
// values 0..3 and even values are settled without a division, multiples
// of 3 by one division, otherwise 2 + 2*k divisions are run, where k is
// the number of divisor pairs tried, k up to sqrt(number)/6.
// a finished result is held in a register until out_ready takes it; while
// the receiver stalls no new candidate is accepted.
// reset returns the block to idle with no result pending.
`default_nettype none

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] number,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        is_prime
);

    import tdp_pkg::*;

    localparam int W = VALUE_WIDTH;

    state_t         state_reg, state_next;
    logic [W-1:0]   n_reg, n_next;
    logic [W-1:0]   d_reg, d_next;
    logic           prime_reg, prime_next;

    logic           div_start;
    logic [W-1:0]   div_divisor;
    logic           div_done;
    logic [W-1:0]   div_quo;
    logic [W-1:0]   div_rem;
    logic           rem_zero;

    assign rem_zero = (div_rem == '0);

    tdp_divider #(
        .WIDTH(W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        prime_next = prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = number;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg < W'(MIN_PRIME))
                begin
                    prime_next = 1'b0;
                    state_next = ST_RESULT;
                end
                else if (n_reg <= W'(LAST_SMALL_PRIME))
                begin
                    prime_next = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (!n_reg[0])
                begin
                    prime_next = 1'b0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        d_next     = W'(FIRST_DIVISOR);
                        state_next = ST_DIV_LO;
                    end
                end
            end
            ST_DIV_LO:
            begin
                if (div_done)
                begin
                    if (d_reg > div_quo)
                    begin
                        prime_next = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else if (rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_DIV_HI;
                    end
                end
            end
            ST_DIV_HI:
            begin
                if (div_done)
                begin
                    if (rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        d_next     = d_reg + W'(DIVISOR_STRIDE);
                        state_next = ST_DIV_LO;
                    end
                end
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        div_start   = 1'b0;
        div_divisor = W'(LAST_SMALL_PRIME);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHECK:
            begin
                div_start   = (n_reg > W'(LAST_SMALL_PRIME)) && n_reg[0];
                div_divisor = W'(LAST_SMALL_PRIME);
            end
            ST_DIV3:
            begin
                div_start   = div_done && !rem_zero;
                div_divisor = W'(FIRST_DIVISOR);
            end
            ST_DIV_LO:
            begin
                div_start   = div_done && (d_reg <= div_quo) && !rem_zero;
                div_divisor = d_reg + W'(PAIR_OFFSET);
            end
            ST_DIV_HI:
            begin
                div_start   = div_done && !rem_zero;
                div_divisor = d_reg + W'(DIVISOR_STRIDE);
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        prime_reg <= prime_next;
    end

    assign is_prime = prime_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_trial_division_prime_test.sv */
`timescale 1ns / 1ps

module tb_trial_division_prime_test;
    import tdp_pkg::*;

    localparam int VW             = 31;
    localparam int N_RANDOM       = 75;
    localparam int IDLE_PCT       = 20;
    localparam int BURST_LO       = 45;
    localparam int BURST_HI       = 80;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 2000000;

    typedef struct {
        logic [VW-1:0] value;
        bit            drain;
    } candidate_t;

    typedef struct {
        logic [VW-1:0] value;
        bit            prime;
    } verdict_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_ready;
    logic [VW-1:0] number    = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic          is_prime;

    candidate_t candidates_pending[$];
    verdict_t   verdicts_due[$];

    bit in_took      = 1'b0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_primes     = 0;
    int n_errors     = 0;
    int idle_cycles  = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .number   (number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .is_prime (is_prime)
    );

    always #2 clk = ~clk;

    function automatic bit prime_of(longint unsigned n);
        longint unsigned d;
        if (n < MIN_PRIME)
            return 1'b0;
        if (n <= LAST_SMALL_PRIME)
            return 1'b1;
        if ((n % 2) == 0 || (n % 3) == 0)
            return 1'b0;
        for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STRIDE)
        begin
            if ((n % d) == 0)
                return 1'b0;
            if ((n % (d + PAIR_OFFSET)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic add_candidate(longint unsigned value, bit drain);
        candidate_t c;
        c.value = value[VW-1:0];
        c.drain = drain;
        candidates_pending.push_back(c);
    endtask

    // large values with a small factor keep the divider loop short
    function automatic longint unsigned wide_composite();
        int unsigned factors[10] = '{2, 5, 7, 11, 13, 17, 19, 23, 29, 37};
        longint unsigned r;
        int unsigned p;
        r = {$urandom()} & ((64'd1 << VW) - 1);
        p = factors[$urandom_range(0, 9)];
        return r - (r % p);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (candidates_pending.size() > 0
                && !(candidates_pending[0].drain && verdicts_due.size() > 0)
                && ((n_sent >= BURST_LO && n_sent < BURST_HI)
                    || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                number   <= candidates_pending[0].value;
                void'(candidates_pending.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= (n_checked >= BURST_LO && n_checked < BURST_HI)
                         || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n)
        begin
            in_took <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                v.value = number;
                v.prime = prime_of(number);
                verdicts_due.push_back(v);
                n_sent++;
                if (v.prime)
                    n_primes++;
            end
            if (out_valid && out_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result beat, is_prime=%b", is_prime));
                end
                else
                begin
                    v = verdicts_due.pop_front();
                    if (is_prime !== v.prime)
                        report_mismatch($sformatf("number %0d: is_prime=%b, want %b",
                                                  v.value, is_prime, v.prime));
                end
                n_checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, verdicts_due.size());
                $display("[trial_division_prime_test] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        longint unsigned directed[$];
        int unsigned pick;
        directed = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 35, 49, 121, 169, 289,
                     65521, 65537, 1000003, 32'h5555_5555 & 32'h7fff_ffff,
                     32'h2aaa_aaaa, 32'h4000_0000, 2147483646, 2147483645,
                     2147483647};
        foreach (directed[i])
            add_candidate(directed[i], 1'b0);
        // random beats 0 and 60 wait for all earlier results to drain
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                add_candidate($urandom_range(0, 4095), i == 0 || i == 60);
            else if (pick < 70)
                add_candidate($urandom_range(0, (1 << 20) - 1), i == 0 || i == 60);
            else
                add_candidate(wide_composite(), i == 0 || i == 60);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (candidates_pending.size() > 0 || in_valid || verdicts_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d candidates (%0d directed), %0d of them prime",
                 n_sent, directed.size(), n_primes);
        $display("%0d result beats checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && verdicts_due.size() == 0)
            $display("[trial_division_prime_test] OK");
        else
            $display("[trial_division_prime_test] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/tdp_pkg.sv
rtl/tdp_divider.sv
rtl/trial_division_prime_test.sv
tb/sv/tb_trial_division_prime_test.sv
